// ----- sv/orbit_camera_eye_position_top_defines.svh -----
// ---------------------------------------------------------------------------
// orbit camera eye position assertion macros
// implication checks used by the rtl, empty when built for synthesis
// ---------------------------------------------------------------------------
`ifndef ORBIT_CAMERA_EYE_POSITION_TOP_DEFINES_SVH
`define ORBIT_CAMERA_EYE_POSITION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OCEP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define OCEP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OCEP_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define OCEP_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- sv/ocep_pkg.sv -----
// ---------------------------------------------------------------------------
// ocep_pkg
// shared types, constants and the cordic arctangent table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ocep_pkg;

    // port widths
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 128;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    // angle constants in q3.12 radians
    localparam int ANG_2PI     = 25736;
    localparam int ANG_PI      = 12868;
    localparam int ANG_HALF_PI = 6434;
    localparam int POLAR_CAP   = 6362;

    localparam int RADIUS_MAX  = 16777215;
    localparam int EYE_MAX     = 16777215;

    // cordic start vector, q1.30
    localparam int CORDIC_GAIN = 652032874;

    // floor(n / 10) = (n * RECIP10) >> RECIP10_SHIFT for n below 2^18
    localparam int RECIP10       = 52429;
    localparam int RECIP10_SHIFT = 19;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RADIUS    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_RADIUS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_AZIMUTH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POLAR   = 8'd3;

    typedef struct packed {
        logic               start;
        logic signed [15:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] sin;
        logic signed [31:0] cos;
    } cordic_res_t;

    // atan(2^-i) in q2.29
    function automatic logic signed [31:0] atan_val(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:  v = 32'sd421657428;
            5'd1:  v = 32'sd248918915;
            5'd2:  v = 32'sd131521918;
            5'd3:  v = 32'sd66762579;
            5'd4:  v = 32'sd33510843;
            5'd5:  v = 32'sd16771758;
            5'd6:  v = 32'sd8387925;
            5'd7:  v = 32'sd4194219;
            5'd8:  v = 32'sd2097141;
            5'd9:  v = 32'sd1048575;
            5'd10: v = 32'sd524288;
            5'd11: v = 32'sd262144;
            5'd12: v = 32'sd131072;
            5'd13: v = 32'sd65536;
            5'd14: v = 32'sd32768;
            5'd15: v = 32'sd16384;
            5'd16: v = 32'sd8192;
            5'd17: v = 32'sd4096;
            5'd18: v = 32'sd2048;
            5'd19: v = 32'sd1024;
            5'd20: v = 32'sd512;
            5'd21: v = 32'sd256;
            5'd22: v = 32'sd128;
            5'd23: v = 32'sd64;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ocep_cordic.sv -----
// ---------------------------------------------------------------------------
// ocep_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ocep_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  ocep_pkg::cordic_req_t    req,
    output ocep_pkg::cordic_res_t    res
);
    import ocep_pkg::*;

    localparam int CW = $clog2(STEPS);
    localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

    logic signed [31:0] x_reg, y_reg, z_reg;
    logic signed [31:0] x_next, y_next, z_next;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg, done_reg, neg_reg;

    logic signed [15:0] t_wrap, t_fold;
    logic               neg_w;
    logic signed [31:0] dx, dy, ang;

    // fold the angle into [-pi/2, pi/2]
    always_comb begin
        if (req.angle > ANG_PI) begin
            t_wrap = 16'(req.angle - ANG_2PI);
        end else if (req.angle < -ANG_PI) begin
            t_wrap = 16'(req.angle + ANG_2PI);
        end else begin
            t_wrap = req.angle;
        end
        neg_w = 1'b0;
        if (t_wrap > ANG_HALF_PI) begin
            t_fold = 16'(t_wrap - ANG_PI);
            neg_w  = 1'b1;
        end else if (t_wrap < -ANG_HALF_PI) begin
            t_fold = 16'(t_wrap + ANG_PI);
            neg_w  = 1'b1;
        end else begin
            t_fold = t_wrap;
        end
    end

    always_comb begin
        dx  = y_reg >>> cnt_reg;
        dy  = x_reg >>> cnt_reg;
        ang = atan_val(5'(cnt_reg));
        if (!z_reg[31]) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - ang;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= 32'(CORDIC_GAIN);
                y_reg    <= '0;
                z_reg    <= 32'(t_fold) <<< 17;
                neg_reg  <= neg_w;
            end else if (busy_reg) begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.cos  = neg_reg ? -x_reg : x_reg;
    assign res.sin  = neg_reg ? -y_reg : y_reg;

endmodule

`default_nettype wire

// ----- sv/orbit_camera_eye_position_top.sv -----
// ---------------------------------------------------------------------------
// orbit_camera_eye_position_top
// orbit camera state update and spherical to cartesian eye point
// ---------------------------------------------------------------------------
// usage
//   s_ channel: one request per camera event, s_tdata holds the three deltas,
//   s_tuser the restart flag. a restart reloads angles and radius from the
//   start registers before the deltas apply.
//   m_ channel: one result per request, eye point plus updated state.
//   cfg channel: register writes, always ready; the user writes only while
//   the block is idle, the block itself does not enforce it.
// sequence
//   a request is taken only in the idle state; it then runs the state update
//   (S_TEN_A, S_TEN_P, S_POL_UPD) through the shared multiplier, the single
//   cordic unit (azimuth then polar), and the products in the same 32x32
//   multiplier (S_MUL0 to S_MUL4); S_MUL5 then loads the result for m_tvalid.
// reset and stall
//   aresetn (synchronous, low) restores the register and state reset values.
//   the output register lets the next request in while a result waits; if
//   m_tready is still low when that next result is ready, the sequencer holds
//   in its last step until the waiting result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "orbit_camera_eye_position_top_defines.svh"

module orbit_camera_eye_position_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input requests
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // azimuth_delta[15:0], polar_delta[31:16], zoom_delta[55:32]
    input  wire logic [ocep_pkg::S_TDATA_W-1:0]    s_tdata,
    // restart
    input  wire logic                              s_tuser,
    // results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // eye_x[24:0], eye_y[49:25], eye_z[74:50], azimuth_now[89:75],
    // polar_now[103:90], radius_now[127:104]
    output logic [ocep_pkg::M_TDATA_W-1:0]         m_tdata,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ocep_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ocep_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ocep_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_TEN_A   = 4'd1;  // radius update, azimuth tenth product
    localparam logic [3:0] S_TEN_P   = 4'd2;  // azimuth wrap, polar tenth product
    localparam logic [3:0] S_POL_UPD = 4'd3;  // polar clamp, azimuth cordic start
    localparam logic [3:0] S_CORD_A  = 4'd4;
    localparam logic [3:0] S_CORD_P  = 4'd5;
    localparam logic [3:0] S_MUL0    = 4'd6;
    localparam logic [3:0] S_MUL1    = 4'd7;
    localparam logic [3:0] S_MUL2    = 4'd8;
    localparam logic [3:0] S_MUL3    = 4'd9;
    localparam logic [3:0] S_MUL4    = 4'd10;
    localparam logic [3:0] S_MUL5    = 4'd11;

    logic [3:0] state_reg;

    // configuration registers
    logic [23:0]        min_radius_reg, start_radius_reg;
    logic [14:0]        start_azimuth_reg;
    logic signed [13:0] start_polar_reg;

    // camera state
    logic [14:0]        az_reg;
    logic signed [13:0] pol_reg;
    logic [23:0]        rad_reg;

    // latched request
    logic [16:0]        na_reg, np_reg;       // |delta| + 5
    logic               neg_a_reg, neg_p_reg;
    logic signed [23:0] dz_reg;

    // trig values and intermediate products, q1.30
    logic signed [31:0] sa_reg, ca_reg, sp_reg, cp_reg, cc_reg, cs_reg;
    logic signed [24:0] ex_w_reg, ey_w_reg;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic               mul_en;
    logic signed [63:0] prod_reg;

    // output register
    logic               m_tvalid_reg;
    logic signed [24:0] ex_o_reg, ey_o_reg, ez_o_reg;
    logic [14:0]        az_o_reg;
    logic signed [13:0] pol_o_reg;
    logic [23:0]        rad_o_reg;

    cordic_req_t creq;
    cordic_res_t cres;

    // request decode
    logic signed [16:0] da_ext, dp_ext;
    logic [16:0]        na_w, np_w;

    // state update helpers
    logic [12:0]        q_w;
    logic signed [16:0] a_sum, a_wrap;
    logic signed [15:0] p_sum, p_clamp;
    logic signed [25:0] r_diff, r_clamp;
    logic signed [63:0] rnd_w;
    logic signed [24:0] eye_sat;
    logic               out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_radius_reg    <= 24'd4096;
            start_radius_reg  <= 24'd40960;
            start_azimuth_reg <= '0;
            start_polar_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MIN_RADIUS:    min_radius_reg    <= cfg_wdata;
                REG_START_RADIUS:  start_radius_reg  <= cfg_wdata;
                REG_START_AZIMUTH: start_azimuth_reg <= cfg_wdata[14:0];
                REG_START_POLAR:   start_polar_reg   <= $signed(cfg_wdata[13:0]);
                default: ;  // unknown index is ignored
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------------
    always_comb begin
        // magnitude plus rounding bias for the tenth
        da_ext = $signed({s_tdata[15], s_tdata[15:0]});
        dp_ext = $signed({s_tdata[31], s_tdata[31:16]});
        na_w   = 17'(da_ext[16] ? -da_ext : da_ext) + 17'd5;
        np_w   = 17'(dp_ext[16] ? -dp_ext : dp_ext) + 17'd5;

        // tenth from the last reciprocal product
        q_w = prod_reg[31:RECIP10_SHIFT];

        // azimuth: add and wrap into [0, 2pi)
        if (neg_a_reg) begin
            a_sum = $signed({2'b00, az_reg}) - $signed({4'b0000, q_w});
        end else begin
            a_sum = $signed({2'b00, az_reg}) + $signed({4'b0000, q_w});
        end
        if (a_sum < 0) begin
            a_wrap = a_sum + 17'(ANG_2PI);
        end else if (a_sum >= 17'(ANG_2PI)) begin
            a_wrap = a_sum - 17'(ANG_2PI);
        end else begin
            a_wrap = a_sum;
        end

        // polar: add and clamp to +/-89 degrees
        if (neg_p_reg) begin
            p_sum = 16'(pol_reg) - $signed({3'b000, q_w});
        end else begin
            p_sum = 16'(pol_reg) + $signed({3'b000, q_w});
        end
        if (p_sum > 16'(POLAR_CAP)) begin
            p_clamp = 16'(POLAR_CAP);
        end else if (p_sum < -16'(POLAR_CAP)) begin
            p_clamp = -16'(POLAR_CAP);
        end else begin
            p_clamp = p_sum;
        end

        // radius: shrink by zoom, lower bound first, then saturate
        r_diff = $signed({2'b00, rad_reg}) - 26'(dz_reg);
        if (r_diff < $signed({2'b00, min_radius_reg})) begin
            r_clamp = $signed({2'b00, min_radius_reg});
        end else if (r_diff > 26'(RADIUS_MAX)) begin
            r_clamp = 26'(RADIUS_MAX);
        end else begin
            r_clamp = r_diff;
        end

        // q1.30 product rounding, half up
        rnd_w = (prod_reg + 64'sd536870912) >>> 30;
        if (rnd_w > 64'(EYE_MAX)) begin
            eye_sat = 25'(EYE_MAX);
        end else if (rnd_w < -64'(EYE_MAX)) begin
            eye_sat = -25'(EYE_MAX);
        end else begin
            eye_sat = rnd_w[24:0];
        end
    end

    // multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        unique case (state_reg)
            S_TEN_A: begin
                mul_a = $signed({15'b0, na_reg});
                mul_b = 32'(RECIP10);
            end
            S_TEN_P: begin
                mul_a = $signed({15'b0, np_reg});
                mul_b = 32'(RECIP10);
            end
            S_MUL0: begin
                mul_a = cp_reg;
                mul_b = ca_reg;
            end
            S_MUL1: begin
                mul_a = cp_reg;
                mul_b = sa_reg;
            end
            S_MUL2: begin
                mul_a = $signed({8'b0, rad_reg});
                mul_b = sp_reg;
            end
            S_MUL3: begin
                mul_a = $signed({8'b0, rad_reg});
                mul_b = cc_reg;
            end
            S_MUL4: begin
                mul_a = $signed({8'b0, rad_reg});
                mul_b = cs_reg;
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // cordic requests: azimuth first, polar as soon as azimuth is done
    always_comb begin
        creq.start = (state_reg == S_POL_UPD) || ((state_reg == S_CORD_A) && cres.done);
        if (state_reg == S_POL_UPD) begin
            creq.angle = $signed({1'b0, az_reg});
        end else begin
            creq.angle = 16'(pol_reg);
        end
    end

    ocep_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .res     (cres)
    );

    // ---------------------------------------------------------------------
    // sequencer and state
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            az_reg       <= '0;
            pol_reg      <= '0;
            rad_reg      <= 24'd40960;
            m_tvalid_reg <= 1'b0;
        end else begin
            // taken result clears, unless a new one loads at the same edge
            if (m_tvalid_reg && m_tready && !((state_reg == S_MUL5) && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser) begin
                            az_reg  <= start_azimuth_reg;
                            pol_reg <= start_polar_reg;
                            rad_reg <= start_radius_reg;
                        end
                        na_reg    <= na_w;
                        np_reg    <= np_w;
                        neg_a_reg <= s_tdata[15];
                        neg_p_reg <= s_tdata[31];
                        dz_reg    <= $signed(s_tdata[55:32]);
                        state_reg <= S_TEN_A;
                    end
                end
                S_TEN_A: begin
                    rad_reg   <= r_clamp[23:0];
                    state_reg <= S_TEN_P;
                end
                S_TEN_P: begin
                    az_reg    <= a_wrap[14:0];
                    state_reg <= S_POL_UPD;
                end
                S_POL_UPD: begin
                    pol_reg   <= p_clamp[13:0];
                    state_reg <= S_CORD_A;
                end
                S_CORD_A: begin
                    if (cres.done) begin
                        sa_reg    <= cres.sin;
                        ca_reg    <= cres.cos;
                        state_reg <= S_CORD_P;
                    end
                end
                S_CORD_P: begin
                    if (cres.done) begin
                        sp_reg    <= cres.sin;
                        cp_reg    <= cres.cos;
                        state_reg <= S_MUL0;
                    end
                end
                S_MUL0: state_reg <= S_MUL1;
                S_MUL1: begin
                    cc_reg    <= rnd_w[31:0];
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    cs_reg    <= rnd_w[31:0];
                    state_reg <= S_MUL3;
                end
                S_MUL3: begin
                    ey_w_reg  <= eye_sat;
                    state_reg <= S_MUL4;
                end
                S_MUL4: begin
                    ex_w_reg  <= eye_sat;
                    state_reg <= S_MUL5;
                end
                S_MUL5: begin
                    // hold here until the output register is free
                    if (out_free) begin
                        ex_o_reg     <= ex_w_reg;
                        ey_o_reg     <= ey_w_reg;
                        ez_o_reg     <= eye_sat;
                        az_o_reg     <= az_reg;
                        pol_o_reg    <= pol_reg;
                        rad_o_reg    <= rad_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {rad_o_reg, pol_o_reg, az_o_reg, ez_o_reg, ey_o_reg, ex_o_reg};

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    `OCEP_ASSERT_IMP(a_cordic_done_in_wait, aclk, aresetn, cres.done,
        (state_reg == S_CORD_A) || (state_reg == S_CORD_P),
        "cordic finished outside a wait step")
    `OCEP_ASSERT_IMP(a_azimuth_wrapped, aclk, aresetn, state_reg == S_MUL0,
        az_reg < 15'(ANG_2PI), "azimuth not wrapped before products")
    `OCEP_ASSERT_IMP(a_polar_clamped, aclk, aresetn, state_reg == S_MUL0,
        (pol_reg <= 14'(POLAR_CAP)) && (pol_reg >= -14'(POLAR_CAP)),
        "polar angle outside clamp")
    `OCEP_ASSERT_IMP(a_radius_bound, aclk, aresetn, state_reg == S_MUL0,
        rad_reg >= min_radius_reg, "radius below lower bound")
    `OCEP_ASSERT_NXT(a_hold_on_stall, aclk, aresetn,
        (state_reg == S_MUL5) && m_tvalid_reg && !m_tready,
        (state_reg == S_MUL5) && m_tvalid_reg,
        "result register overwritten while stalled")

endmodule

`default_nettype wire

// ----- verif/orbit_eye_checker.sv -----
// ---------------------------------------------------------------------------
// orbit_eye_checker
// watches the request, result and register channels of the orbit camera,
// predicts each eye point from its own copy of the camera state and compares
// the results field by field in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module orbit_eye_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [ocep_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [ocep_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [ocep_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ocep_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int unsigned                            mismatch_count = 0,
    output int unsigned                            eye_points_pending = 0,
    output int unsigned                            eye_points_checked = 0
);
    import ocep_pkg::*;

    typedef struct packed {
        logic signed [24:0] eye_x;
        logic signed [24:0] eye_y;
        logic signed [24:0] eye_z;
        logic        [14:0] azimuth_now;
        logic signed [13:0] polar_now;
        logic        [23:0] radius_now;
    } eye_point_t;

    // atan(2^-i), q2.29
    longint atan_q229 [0:23] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096,
        2048, 1024, 512, 256, 128, 64
    };

    // register copies
    longint min_rad, start_rad;
    int     start_az, start_pol;
    // camera state copy
    int     az_q, pol_q;
    longint rad_q;

    eye_point_t eye_points_due [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR result %0d: %s", $realtime, eye_points_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // one tenth, rounded to nearest with ties away from zero
    function automatic int tenth_of(input int d);
        int m;
        m = (d < 0) ? -d : d;
        m = (m + 5) / 10;
        return (d < 0) ? -m : m;
    endfunction

    // product of two fixed point values scaled down by 2^30, rounded half up
    function automatic longint round_q30(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clip_eye(input longint v);
        if (v > EYE_MAX) return EYE_MAX;
        if (v < -EYE_MAX) return -EYE_MAX;
        return v;
    endfunction

    // sine and cosine in q1.30 of a q3.12 angle
    function automatic void cordic_sin_cos(input int ang, output longint s_q130,
                                           output longint c_q130);
        longint x, y, z, dx, dy;
        int     t;
        bit     flip;
        t = ang;
        flip = 1'b0;
        if (t > ANG_PI) t -= ANG_2PI;
        if (t < -ANG_PI) t += ANG_2PI;
        // fold into the right half plane, negate at the end
        if (t > ANG_HALF_PI) begin
            t -= ANG_PI;
            flip = 1'b1;
        end else if (t < -ANG_HALF_PI) begin
            t += ANG_PI;
            flip = 1'b1;
        end
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = longint'(t) * 131072;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_q229[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_q229[i];
            end
        end
        c_q130 = flip ? -x : x;
        s_q130 = flip ? -y : y;
    endfunction

    // applies one camera request to the state copy and returns the eye point
    function automatic eye_point_t advance_orbit(input logic [S_TDATA_W-1:0] req,
                                                 input logic restart);
        eye_point_t e;
        int     da, dp, a, p;
        longint dz, r, sa, ca, sp, cp;
        da = int'($signed(req[15:0]));
        dp = int'($signed(req[31:16]));
        dz = longint'($signed(req[55:32]));
        if (restart) begin
            az_q  = start_az;
            pol_q = start_pol;
            rad_q = start_rad;
        end
        a = (az_q + tenth_of(da)) % ANG_2PI;
        if (a < 0) a += ANG_2PI;
        az_q = a;
        p = pol_q + tenth_of(dp);
        if (p > POLAR_CAP) p = POLAR_CAP;
        if (p < -POLAR_CAP) p = -POLAR_CAP;
        pol_q = p;
        // lower bound first, upper saturation after it
        r = rad_q - dz;
        if (r < min_rad) r = min_rad;
        if (r > RADIUS_MAX) r = RADIUS_MAX;
        rad_q = r;
        cordic_sin_cos(az_q, sa, ca);
        cordic_sin_cos(pol_q, sp, cp);
        e.eye_x       = 25'(clip_eye(round_q30(r, round_q30(cp, ca))));
        e.eye_y       = 25'(clip_eye(round_q30(r, sp)));
        e.eye_z       = 25'(clip_eye(round_q30(r, round_q30(cp, sa))));
        e.azimuth_now = 15'(az_q);
        e.polar_now   = 14'(pol_q);
        e.radius_now  = 24'(rad_q);
        return e;
    endfunction

    always @(posedge aclk) begin
        eye_point_t got, want;
        if (!aresetn) begin
            min_rad   = 4096;
            start_rad = 40960;
            start_az  = 0;
            start_pol = 0;
            az_q      = 0;
            pol_q     = 0;
            rad_q     = 40960;
            eye_points_due.delete();
        end else begin
            // results first, so a request taken at this edge cannot match
            if (m_tvalid && m_tready) begin
                got.eye_x       = m_tdata[24:0];
                got.eye_y       = m_tdata[49:25];
                got.eye_z       = m_tdata[74:50];
                got.azimuth_now = m_tdata[89:75];
                got.polar_now   = m_tdata[103:90];
                got.radius_now  = m_tdata[127:104];
                if (eye_points_due.size() == 0) begin
                    report_mismatch("result arrived with no request outstanding");
                end else begin
                    want = eye_points_due.pop_front();
                    check_field("eye_x", got.eye_x, want.eye_x);
                    check_field("eye_y", got.eye_y, want.eye_y);
                    check_field("eye_z", got.eye_z, want.eye_z);
                    check_field("azimuth_now", got.azimuth_now, want.azimuth_now);
                    check_field("polar_now", got.polar_now, want.polar_now);
                    check_field("radius_now", got.radius_now, want.radius_now);
                end
                eye_points_checked++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_RADIUS:    min_rad   = longint'(cfg_wdata);
                    REG_START_RADIUS:  start_rad = longint'(cfg_wdata);
                    REG_START_AZIMUTH: start_az  = int'(cfg_wdata[14:0]);
                    REG_START_POLAR:   start_pol = int'($signed(cfg_wdata[13:0]));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                eye_points_due.push_back(advance_orbit(s_tdata, s_tuser));
        end
        eye_points_pending <= eye_points_due.size();
    end

endmodule

// ----- verif/tb_orbit_camera_eye_position_top.sv -----
// ---------------------------------------------------------------------------
// tb_orbit_camera_eye_position_top
// drives camera requests and register writes into the orbit camera block
// and gives the verdict; the checker beside the block predicts and compares
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_orbit_camera_eye_position_top;
    import ocep_pkg::*;

    localparam int     CORDIC_STEPS   = 16;
    localparam int     CLK_HALF_NS    = 4;
    localparam longint TIMEOUT_NS     = 64'd8_000_000;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     END_CYCLES     = 60;
    localparam int     RX_HOLD_CYCLES = 400;
    localparam int     PHASE_REQS     = 640;

    // register indexes the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 8'd255;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;   // azimuth_delta, polar_delta, zoom_delta
    logic                    s_tuser   = 1'b0; // restart
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;          // eye_x/y/z, azimuth, polar, radius
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    int unsigned mismatch_count, eye_points_pending, eye_points_checked;

    // idle rates in percent: of requests for the sender, of cycles for the receiver
    int tx_idle_pct = 9;
    int rx_idle_pct = 80;

    // long receiver hold-off, armed by the stimulus
    bit   hold_go = 1'b0;
    logic rx_hold = 1'b0;

    int unsigned requests_sent = 0;
    int unsigned restarts_sent = 0;
    int unsigned settings_used = 1;   // reset values count as the first

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    orbit_camera_eye_position_top #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    orbit_eye_checker #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .mismatch_count     (mismatch_count),
        .eye_points_pending (eye_points_pending),
        .eye_points_checked (eye_points_checked)
    );

    // result side backpressure: random stalls, or held low during the hold-off
    always @(posedge aclk) begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // hold-off counted here while the sender keeps offering requests, so the
    // output register and the pipeline fill and s_tready drops
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout: %0d results still outstanding", eye_points_pending);
        $display("Some tests failed");
        $finish;
    end

    // one camera request; valid stays high across back-to-back requests
    task automatic send_event(input logic signed [15:0] az_delta,
                              input logic signed [15:0] pol_delta,
                              input logic signed [23:0] zoom_delta,
                              input logic restart);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 60);   // long enough to land on any pipeline step
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {zoom_delta, pol_delta, az_delta};
        s_tuser  <= restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        if (restart) restarts_sent++;
    endtask

    // register write; valid only drops after the last one of a batch
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (last) cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (eye_points_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_setting(input logic [CFG_DATA_W-1:0] min_r,
                                input logic [CFG_DATA_W-1:0] start_r,
                                input logic [CFG_DATA_W-1:0] start_a,
                                input logic [CFG_DATA_W-1:0] start_p);
        write_reg(REG_MIN_RADIUS, min_r, 1'b0);
        write_reg(REG_START_RADIUS, start_r, 1'b0);
        write_reg(REG_START_AZIMUTH, start_a, 1'b0);
        write_reg(REG_START_POLAR, start_p, 1'b1);
        settings_used++;
    endtask

    // random camera traffic, mostly full-scale angle jumps with some moderate motion
    task automatic run_random_phase(input int count, input bit with_hold);
        logic signed [15:0] az_d, pol_d;
        logic signed [23:0] zoom_d;
        logic               rst;
        int                 sel;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 70) az_d = 16'($urandom);
            else                         az_d = 16'($urandom_range(4096) - 2048);
            if ($urandom_range(99) < 70) pol_d = 16'($urandom);
            else                         pol_d = 16'($urandom_range(4096) - 2048);
            sel = $urandom_range(99);
            if (sel < 15)      zoom_d = '0;
            else if (sel < 60) zoom_d = 24'($urandom_range(16384) - 8192);
            else if (sel < 85) zoom_d = 24'($urandom_range(2097152) - 1048576);
            else               zoom_d = 24'($urandom);
            rst = ($urandom_range(99) < 6);
            // sender pauses mid phase until the block has emptied
            if (i == count / 2) wait_drained();
            if (with_hold && i == count / 4) hold_go = 1'b1;
            send_event(az_d, pol_d, zoom_d, rst);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset register values
        send_event(16'sd0, 16'sd0, 24'sd0, 1'b0);
        send_event(16'sd0, 16'sd0, 24'sd0, 1'b1);
        send_event(16'sd5, -16'sd5, 24'sd0, 1'b0);          // ties round away from zero
        send_event(-16'sd15, 16'sd15, 24'sd0, 1'b0);
        send_event(16'sd4, -16'sd4, 24'sd1, 1'b0);
        send_event(-16'sd32768, 16'sd0, 24'sd0, 1'b0);      // large azimuth step down
        send_event(16'sd32767, 16'sd0, 24'sd0, 1'b0);       // back up to just below 2pi
        send_event(16'sd0, 16'sd32767, 24'sd0, 1'b0);       // polar toward +89 deg
        send_event(16'sd0, 16'sd32767, 24'sd0, 1'b0);
        send_event(16'sd0, -16'sd32768, 24'sd0, 1'b0);
        send_event(16'sd0, -16'sd32768, 24'sd0, 1'b0);      // polar back just below zero
        send_event(16'sd0, 16'sd0, -24'sd8388608, 1'b0);    // zoom out to radius ceiling
        send_event(16'sd0, 16'sd0, -24'sd8388608, 1'b0);
        send_event(16'sd0, 16'sd0, -24'sd8388608, 1'b0);
        send_event(16'sd0, 16'sd0, 24'sd8388607, 1'b0);     // zoom in to min radius
        send_event(16'sd0, 16'sd0, 24'sd8388607, 1'b0);
        send_event(16'sd0, 16'sd0, 24'sd8388607, 1'b0);
        wait_drained();

        // out-of-range start angles, no lower radius bound, unmapped indexes
        load_setting(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'h002000);
        write_reg(REG_UNMAPPED_LO, 24'h000000, 1'b0);
        write_reg(REG_UNMAPPED_HI, 24'h00007B, 1'b1);
        send_event(16'sd0, 16'sd0, 24'sd0, 1'b1);
        send_event(16'sd0, 16'sd0, 24'sd8388607, 1'b1);
        send_event(-16'sd32768, 16'sd32767, 24'sd0, 1'b1);
        wait_drained();

        // min radius at the ceiling, start radius zero, start angles at their top
        load_setting(24'hFFFFFF, 24'd0, 24'd25735, 24'd6362);
        send_event(16'sd0, 16'sd0, 24'sd0, 1'b1);
        send_event(16'sd10, 16'sd0, -24'sd8388608, 1'b1);
        send_event(16'sd0, 16'sd0, 24'sd8388607, 1'b0);
        wait_drained();

        // random: sender idles rarely, receiver stalls most cycles
        load_setting(24'($urandom_range(40960)), 24'($urandom_range(4096, 400000)),
                     24'($urandom_range(25735)), 24'($urandom_range(12724) - 6362));
        run_random_phase(PHASE_REQS, 1'b0);
        wait_drained();

        // random: sender idles most cycles, receiver rarely
        tx_idle_pct = 80;
        rx_idle_pct <= 9;
        load_setting(24'($urandom_range(1048576)), 24'($urandom), 24'($urandom),
                     24'($urandom));
        run_random_phase(PHASE_REQS, 1'b0);
        wait_drained();

        // random: full rate on both sides, with one long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        load_setting(24'd0, 24'($urandom), 24'($urandom_range(32767)),
                     24'($urandom_range(16383)));
        run_random_phase(PHASE_REQS, 1'b1);

        wait_drained();
        repeat (END_CYCLES) @(posedge aclk);

        $display("covered %0d camera requests (%0d restarts) under %0d register settings",
                 requests_sent, restarts_sent, settings_used);
        $display("checked %0d eye points, %0d mismatches", eye_points_checked,
                 mismatch_count);
        if (mismatch_count == 0 && eye_points_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ocep_pkg.sv
sv/ocep_cordic.sv
sv/orbit_camera_eye_position_top.sv
verif/orbit_eye_checker.sv
verif/tb_orbit_camera_eye_position_top.sv
